/* rtl/jms_pkg.sv */
// package for the jpeg marker scanner: codes, constants and types
package jms_pkg;

    localparam int OFFSET_BITS_DEF = 32;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_WINDOW = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCAN_THROUGH = 1'b1;

    localparam logic [15:0] START_WINDOW_RST = 16'd255;

    localparam logic [7:0] BYTE_FF    = 8'hff;
    localparam logic [7:0] BYTE_ZERO  = 8'h00;
    localparam logic [7:0] CODE_SOI   = 8'hd8;
    localparam logic [7:0] CODE_EOI   = 8'hd9;
    localparam logic [7:0] CODE_SOS   = 8'hda;
    localparam logic [7:0] CODE_APP13 = 8'hed;
    localparam logic [7:0] CODE_RST0  = 8'hd0;
    localparam logic [7:0] CODE_RST7  = 8'hd7;

    typedef enum logic [2:0] {
        KIND_SOI     = 3'd0,
        KIND_SEG     = 3'd1,
        KIND_SOS     = 3'd2,
        KIND_EOI     = 3'd3,
        KIND_NOSTART = 3'd4,
        KIND_BADLEN  = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_FF      = 3'd1,
        MODE_LENH    = 3'd2,
        MODE_LENL    = 3'd3,
        MODE_SKIP    = 3'd4,
        MODE_SCAN    = 3'd5,
        MODE_SCAN_FF = 3'd6
    } t_mode;

endpackage

/* rtl/jpeg_marker_scanner_top.sv */
// jpeg marker scanner: byte stream in, one marker event per recognized marker out
//
// input channel: i_in_valid / o_in_ready carry one file byte per request, with
// i_new_file marking the first byte of a file (parser state cleared, config kept).
// output channel: o_out_valid / i_out_ready carry at most one marker event per byte:
// kind, code, length field, 0xff offset (byte offset if no start), parser stopped flag.
// config: i_cfg_we writes i_cfg_wdata to register i_cfg_index (0 start window,
// 1 scan through) in the same cycle; write only while no request is in flight.
// a byte waits in the input register until the event register is free or being read,
// then the parser state and the event register update together from it.
// throughput: one byte per cycle while the receiver takes the events.
// a stalled receiver holds the event register; the input register still takes a
// byte, and the next one waits only while both registers are full.
// reset (synchronous, active low) clears the parser, both registers' valid flags
// and loads the config defaults (start window 255, scan through off).
module jpeg_marker_scanner_top #(
    parameter int OFFSET_BITS = jms_pkg::OFFSET_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_new_file,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [2:0]                     o_event_kind,
    output logic [7:0]                     o_marker_code,
    output logic [15:0]                    o_segment_length,
    output logic [31:0]                    o_marker_offset,
    output logic                           o_scan_ended,
    input  logic                           i_cfg_we,
    input  logic [jms_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [jms_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int CMP_W = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;

    // config registers
    logic [15:0] r_start_window;
    logic        r_scan_through;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_new_file;

    // parser state
    jms_pkg::t_mode         r_mode, n_mode;
    logic [15:0]            r_skip, n_skip;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic                   r_seen, n_seen;
    logic                   r_halted, n_halted;
    logic [7:0]             r_code, n_code;
    logic [7:0]             r_lenh, n_lenh;

    // event register
    logic                   r_out_valid;
    jms_pkg::t_kind         r_kind;
    logic [7:0]             r_ev_code;
    logic [15:0]            r_ev_len;
    logic [31:0]            r_ev_off;
    logic                   r_ev_ends;

    logic                   advance;
    logic                   emit;
    jms_pkg::t_kind         ev_kind;
    logic [7:0]             ev_code;
    logic [15:0]            ev_len;
    logic [OFFSET_BITS-1:0] ev_off;
    logic                   ev_ends;
    logic [OFFSET_BITS+31:0] off_ext;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_window <= jms_pkg::START_WINDOW_RST;
            r_scan_through <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                jms_pkg::CFG_START_WINDOW: r_start_window <= i_cfg_wdata;
                jms_pkg::CFG_SCAN_THROUGH: r_scan_through <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_byte     <= i_data_byte;
            r_new_file <= i_new_file;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= jms_pkg::MODE_IDLE;
            r_skip   <= '0;
            r_pos    <= '0;
            r_seen   <= 1'b0;
            r_halted <= 1'b0;
            r_code   <= '0;
            r_lenh   <= '0;
        end else if (advance) begin
            r_mode   <= n_mode;
            r_skip   <= n_skip;
            r_pos    <= n_pos;
            r_seen   <= n_seen;
            r_halted <= n_halted;
            r_code   <= n_code;
            r_lenh   <= n_lenh;
        end
    end

    // next state and event for the byte in the input register
    always_comb begin
        logic                   marker_hit;
        logic [15:0]            len;
        logic [CMP_W-1:0]       pos_cmp;
        logic [CMP_W-1:0]       win_cmp;
        jms_pkg::t_mode         e_mode;
        logic [15:0]            e_skip;
        logic [OFFSET_BITS-1:0] e_pos;
        logic                   e_seen;
        logic                   e_halted;
        logic [7:0]             e_code;
        logic [7:0]             e_lenh;

        // new file clears the parser before the byte is taken
        e_mode   = r_new_file ? jms_pkg::MODE_IDLE : r_mode;
        e_skip   = r_new_file ? 16'd0 : r_skip;
        e_pos    = r_new_file ? '0 : r_pos;
        e_seen   = r_new_file ? 1'b0 : r_seen;
        e_halted = r_new_file ? 1'b0 : r_halted;
        e_code   = r_new_file ? 8'd0 : r_code;
        e_lenh   = r_new_file ? 8'd0 : r_lenh;

        n_mode   = e_mode;
        n_skip   = e_skip;
        n_pos    = e_pos;
        n_seen   = e_seen;
        n_halted = e_halted;
        n_code   = e_code;
        n_lenh   = e_lenh;

        emit       = 1'b0;
        ev_kind    = jms_pkg::KIND_SOI;
        ev_code    = 8'd0;
        ev_len     = 16'd0;
        ev_off     = e_pos;
        ev_ends    = 1'b0;
        marker_hit = 1'b0;
        len        = {e_lenh, r_byte};
        pos_cmp    = CMP_W'(e_pos);
        win_cmp    = CMP_W'(r_start_window);

        if (!e_halted) begin
            n_pos = e_pos + OFFSET_BITS'(1);
            if (!e_seen && (r_start_window != 16'd0) && (pos_cmp >= win_cmp)) begin
                emit    = 1'b1;
                ev_kind = jms_pkg::KIND_NOSTART;
                ev_ends = 1'b1;
            end else begin
                unique case (e_mode)
                    jms_pkg::MODE_IDLE: begin
                        if (r_byte == jms_pkg::BYTE_FF) begin
                            n_mode = jms_pkg::MODE_FF;
                        end else if (!e_seen) begin
                            emit    = 1'b1;
                            ev_kind = jms_pkg::KIND_NOSTART;
                            ev_ends = 1'b1;
                        end
                    end
                    jms_pkg::MODE_FF: begin
                        marker_hit = 1'b1;
                    end
                    jms_pkg::MODE_LENH: begin
                        n_lenh = r_byte;
                        n_mode = jms_pkg::MODE_LENL;
                    end
                    jms_pkg::MODE_LENL: begin
                        emit    = 1'b1;
                        ev_code = e_code;
                        ev_len  = len;
                        ev_off  = e_pos - OFFSET_BITS'(3);
                        if (len < 16'd2) begin
                            n_mode  = jms_pkg::MODE_IDLE;
                            ev_kind = jms_pkg::KIND_BADLEN;
                            ev_ends = 1'b1;
                        end else begin
                            n_skip  = len - 16'd2;
                            n_mode  = (len == 16'd2) ? jms_pkg::MODE_IDLE
                                                     : jms_pkg::MODE_SKIP;
                            ev_kind = jms_pkg::KIND_SEG;
                            ev_ends = (e_code == jms_pkg::CODE_APP13);
                        end
                    end
                    jms_pkg::MODE_SKIP: begin
                        n_skip = e_skip - 16'd1;
                        if (e_skip == 16'd1) begin
                            n_mode = jms_pkg::MODE_IDLE;
                        end
                    end
                    jms_pkg::MODE_SCAN: begin
                        if (r_byte == jms_pkg::BYTE_FF) begin
                            n_mode = jms_pkg::MODE_SCAN_FF;
                        end
                    end
                    jms_pkg::MODE_SCAN_FF: begin
                        if (r_byte == jms_pkg::BYTE_FF) begin
                            n_mode = jms_pkg::MODE_SCAN_FF;
                        end else if ((r_byte == jms_pkg::BYTE_ZERO) ||
                                     ((r_byte >= jms_pkg::CODE_RST0) &&
                                      (r_byte <= jms_pkg::CODE_RST7))) begin
                            n_mode = jms_pkg::MODE_SCAN;
                        end else begin
                            marker_hit = 1'b1;
                        end
                    end
                    default: begin
                        n_mode = jms_pkg::MODE_IDLE;
                    end
                endcase

                // byte after 0xff
                if (marker_hit) begin
                    ev_code = r_byte;
                    ev_off  = e_pos - OFFSET_BITS'(1);
                    unique case (r_byte)
                        jms_pkg::BYTE_FF: begin
                            n_mode = jms_pkg::MODE_FF;
                        end
                        jms_pkg::CODE_SOI: begin
                            n_mode  = jms_pkg::MODE_IDLE;
                            n_seen  = 1'b1;
                            emit    = 1'b1;
                            ev_kind = jms_pkg::KIND_SOI;
                        end
                        jms_pkg::CODE_EOI: begin
                            n_mode  = jms_pkg::MODE_IDLE;
                            emit    = 1'b1;
                            ev_kind = jms_pkg::KIND_EOI;
                            ev_ends = 1'b1;
                        end
                        jms_pkg::CODE_SOS: begin
                            n_mode  = jms_pkg::MODE_SCAN;
                            emit    = 1'b1;
                            ev_kind = jms_pkg::KIND_SOS;
                            ev_ends = !r_scan_through;
                        end
                        default: begin
                            n_code = r_byte;
                            n_mode = jms_pkg::MODE_LENH;
                        end
                    endcase
                end

                if (emit && ev_ends) begin
                    n_halted = 1'b1;
                end
            end
            if (emit && ev_ends) begin
                n_halted = 1'b1;
            end
        end
    end

    assign off_ext = {32'd0, ev_off};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_kind    <= ev_kind;
            r_ev_code <= ev_code;
            r_ev_len  <= ev_len;
            r_ev_off  <= off_ext[31:0];
            r_ev_ends <= ev_ends;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_event_kind     = r_kind;
    assign o_marker_code    = r_ev_code;
    assign o_segment_length = r_ev_len;
    assign o_marker_offset  = r_ev_off;
    assign o_scan_ended     = r_ev_ends;

endmodule

/* rtl/jms_checker.sv */
// port-level checks for the jpeg marker scanner, bound to the top level
module jms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_event_kind,
    input logic [15:0] o_segment_length,
    input logic [31:0] o_marker_offset,
    input logic        o_scan_ended
);

    // a stalled event stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("event dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_event_kind) && $stable(o_marker_offset))
        else $error("event changed while stalled");

    // terminating kinds always stop the parser, soi never does
    a_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_event_kind == jms_pkg::KIND_SOI) && !o_scan_ended) ||
            (o_event_kind == jms_pkg::KIND_SEG) ||
            (o_event_kind == jms_pkg::KIND_SOS) ||
            ((o_event_kind == jms_pkg::KIND_EOI) && o_scan_ended) ||
            ((o_event_kind == jms_pkg::KIND_NOSTART) && o_scan_ended) ||
            ((o_event_kind == jms_pkg::KIND_BADLEN) && o_scan_ended))
        else $error("bad kind or stop flag");

    // length only on segment and bad length events; bad length is below two
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_event_kind == jms_pkg::KIND_SEG) && (o_segment_length >= 16'd2)) ||
            ((o_event_kind == jms_pkg::KIND_BADLEN) && (o_segment_length < 16'd2)) ||
            (o_segment_length == 16'd0))
        else $error("length field does not match kind");

endmodule

bind jpeg_marker_scanner_top jms_checker u_jms_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_event_kind     (o_event_kind),
    .o_segment_length (o_segment_length),
    .o_marker_offset  (o_marker_offset),
    .o_scan_ended     (o_scan_ended)
);

/* bench/testbench.sv */
// bench for the jpeg marker scanner: directed table, random files, events checked in order
module testbench;
    import jms_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 45;
    localparam int DIR_COUNT    = 36;
    localparam int MAX_PRINTS   = 40;

    localparam logic [7:0] CODE_APP0 = 8'he0;
    localparam logic [7:0] CODE_DHT  = 8'hc4;

    localparam logic [15:0] PHASE_WINDOW [N_PHASES] =
        '{16'd255, 16'd0, 16'hffff, 16'd2, 16'd40, 16'd0, 16'd1, 16'd600};
    localparam logic PHASE_SCAN [N_PHASES] =
        '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  code;
        logic [15:0] len;
        logic [31:0] off;
        logic        ends;
    } ev_t;

    typedef struct packed {
        logic                   is_cfg;
        logic [CFG_INDEX_W-1:0] idx;
        logic [7:0]             value;
        logic                   nf;
        logic                   pinned;
        ev_t                    ev;
    } step_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic [7:0]             data_byte = 8'h00;
    logic                   new_file  = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [2:0]             event_kind;
    logic [7:0]             marker_code;
    logic [15:0]            segment_length;
    logic [31:0]            marker_offset;
    logic                   scan_ended;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // parser mirror and its settings
    t_mode       p_mode    = MODE_IDLE;
    logic [15:0] p_skip    = '0;
    logic [31:0] p_pos     = '0;
    logic        p_start   = 1'b0;
    logic        p_halted  = 1'b0;
    logic [7:0]  p_code    = '0;
    logic [7:0]  p_len_hi  = '0;
    logic [15:0] cfg_window = START_WINDOW_RST;
    logic        cfg_scan   = 1'b0;

    ev_t expected_events [$];
    ev_t head_ev;
    int  fail_count  = 0;
    int  sent_bytes  = 0;
    int  cycle_count = 0;
    int  send_idle   = 0;
    int  recv_stall  = 0;
    int  hold_asked  = 0;
    int  hold_seen   = 0;

    step_t dir_steps [DIR_COUNT] = '{
        // stray byte before soi
        '{1'b0, 1'b0, 8'h00, 1'b1, 1'b1, '{KIND_NOSTART, 8'h00, 16'd0, 32'd0, 1'b1}},
        // soi, fill bytes, short segment, ignored stray, app13 with largest length
        '{1'b0, 1'b0, BYTE_FF, 1'b1, 1'b0, '0},
        '{1'b0, 1'b0, CODE_SOI, 1'b0, 1'b1, '{KIND_SOI, CODE_SOI, 16'd0, 32'd0, 1'b0}},
        '{1'b0, 1'b0, BYTE_FF, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, BYTE_FF, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, CODE_APP0, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 8'h03, 1'b0, 1'b1, '{KIND_SEG, CODE_APP0, 16'd3, 32'd3, 1'b0}},
        '{1'b0, 1'b0, 8'h5a, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 8'h77, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, BYTE_FF, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, CODE_APP13, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, BYTE_FF, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, BYTE_FF, 1'b0, 1'b1, '{KIND_SEG, CODE_APP13, 16'hffff, 32'd9, 1'b1}},
        // zero length
        '{1'b0, 1'b0, BYTE_FF, 1'b1, 1'b0, '0},
        '{1'b0, 1'b0, CODE_SOI, 1'b0, 1'b1, '{KIND_SOI, CODE_SOI, 16'd0, 32'd0, 1'b0}},
        '{1'b0, 1'b0, BYTE_FF, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, CODE_DHT, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 8'h00, 1'b0, 1'b1, '{KIND_BADLEN, CODE_DHT, 16'd0, 32'd2, 1'b1}},
        '{1'b1, CFG_SCAN_THROUGH, 8'd1, 1'b0, 1'b0, '0},
        '{1'b1, CFG_START_WINDOW, 8'd3, 1'b0, 1'b0, '0},
        // scan through: stuffing and restart stay in the scan
        '{1'b0, 1'b0, BYTE_FF, 1'b1, 1'b0, '0},
        '{1'b0, 1'b0, CODE_SOI, 1'b0, 1'b1, '{KIND_SOI, CODE_SOI, 16'd0, 32'd0, 1'b0}},
        '{1'b0, 1'b0, BYTE_FF, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, CODE_SOS, 1'b0, 1'b1, '{KIND_SOS, CODE_SOS, 16'd0, 32'd2, 1'b0}},
        '{1'b0, 1'b0, BYTE_FF, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, BYTE_ZERO, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, BYTE_FF, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, CODE_RST7, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, BYTE_FF, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, CODE_EOI, 1'b0, 1'b1, '{KIND_EOI, CODE_EOI, 16'd0, 32'd8, 1'b1}},
        // no soi within the start window
        '{1'b0, 1'b0, BYTE_FF, 1'b1, 1'b0, '0},
        '{1'b0, 1'b0, BYTE_FF, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, BYTE_FF, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, BYTE_FF, 1'b0, 1'b1, '{KIND_NOSTART, 8'h00, 16'd0, 32'd3, 1'b1}}
    };

    jpeg_marker_scanner_top u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_data_byte      (data_byte),
        .i_new_file       (new_file),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_event_kind     (event_kind),
        .o_marker_code    (marker_code),
        .o_segment_length (segment_length),
        .o_marker_offset  (marker_offset),
        .o_scan_ended     (scan_ended),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_wdata      (cfg_wdata)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic ev_t make_event(input t_kind k, input logic [7:0] code,
                                       input logic [15:0] len, input logic [31:0] off,
                                       input logic ends);
        ev_t ev;
        ev.kind = k;
        ev.code = code;
        ev.len  = len;
        ev.off  = off;
        ev.ends = ends;
        if (ends) p_halted = 1'b1;
        return ev;
    endfunction

    // byte after an 0xff
    function automatic bit take_code(input logic [7:0] c, input logic [31:0] at,
                                     output ev_t ev);
        ev = '0;
        if (c == BYTE_FF) begin
            p_mode = MODE_FF;
            return 1'b0;
        end
        if (c == CODE_SOI) begin
            p_mode  = MODE_IDLE;
            p_start = 1'b1;
            ev = make_event(KIND_SOI, c, 16'd0, at - 32'd1, 1'b0);
            return 1'b1;
        end
        if (c == CODE_EOI) begin
            p_mode = MODE_IDLE;
            ev = make_event(KIND_EOI, c, 16'd0, at - 32'd1, 1'b1);
            return 1'b1;
        end
        if (c == CODE_SOS) begin
            p_mode = MODE_SCAN;
            ev = make_event(KIND_SOS, c, 16'd0, at - 32'd1, !cfg_scan);
            return 1'b1;
        end
        p_code = c;
        p_mode = MODE_LENH;
        return 1'b0;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input logic nf, output ev_t ev);
        logic [31:0] at;
        logic [15:0] len;
        bit          got;
        ev  = '0;
        got = 1'b0;
        if (nf) begin
            p_mode   = MODE_IDLE;
            p_skip   = '0;
            p_pos    = '0;
            p_start  = 1'b0;
            p_halted = 1'b0;
            p_code   = '0;
            p_len_hi = '0;
        end
        if (p_halted) return 1'b0;
        at    = p_pos;
        p_pos = p_pos + 32'd1;
        if (!p_start && cfg_window != 16'd0 && at >= {16'd0, cfg_window}) begin
            ev = make_event(KIND_NOSTART, 8'h00, 16'd0, at, 1'b1);
            return 1'b1;
        end
        case (p_mode)
            MODE_IDLE: begin
                if (b == BYTE_FF) begin
                    p_mode = MODE_FF;
                end else if (!p_start) begin
                    ev  = make_event(KIND_NOSTART, 8'h00, 16'd0, at, 1'b1);
                    got = 1'b1;
                end
            end
            MODE_FF: got = take_code(b, at, ev);
            MODE_LENH: begin
                p_len_hi = b;
                p_mode   = MODE_LENL;
            end
            MODE_LENL: begin
                len = {p_len_hi, b};
                if (len < 16'd2) begin
                    p_mode = MODE_IDLE;
                    ev = make_event(KIND_BADLEN, p_code, len, at - 32'd3, 1'b1);
                end else begin
                    p_skip = len - 16'd2;
                    p_mode = (p_skip != 16'd0) ? MODE_SKIP : MODE_IDLE;
                    ev = make_event(KIND_SEG, p_code, len, at - 32'd3, p_code == CODE_APP13);
                end
                got = 1'b1;
            end
            MODE_SKIP: begin
                p_skip = p_skip - 16'd1;
                if (p_skip == 16'd0) p_mode = MODE_IDLE;
            end
            MODE_SCAN: begin
                if (b == BYTE_FF) p_mode = MODE_SCAN_FF;
            end
            MODE_SCAN_FF: begin
                if (b == BYTE_FF) begin
                    p_mode = MODE_SCAN_FF;
                end else if (b == BYTE_ZERO || (b >= CODE_RST0 && b <= CODE_RST7)) begin
                    p_mode = MODE_SCAN;
                end else begin
                    got = take_code(b, at, ev);
                end
            end
            default: p_mode = MODE_IDLE;
        endcase
        return got;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        if (fail_count <= MAX_PRINTS)
            $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    endtask

    task automatic add_expected(input ev_t ev);
        expected_events = {expected_events, ev};
    endtask

    task automatic send_byte(input logic [7:0] b, input logic nf,
                             input bit pinned = 1'b0, input ev_t pinned_ev = '0);
        ev_t ev;
        bit  got;
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        new_file  <= nf;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_bytes++;
        got = parse_byte(b, nf, ev);
        if (pinned) add_expected(pinned_ev);
        else if (got) add_expected(ev);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_events.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_START_WINDOW) cfg_window = val;
        else cfg_scan = val[0];
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_code();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 254));
        while (c == CODE_SOI || c == CODE_EOI || c == CODE_SOS || c == CODE_APP13);
        return c;
    endfunction

    task automatic send_segment(input logic [7:0] code, input int len);
        send_byte(code, 1'b0);
        send_byte(8'(len >> 8), 1'b0);
        send_byte(8'(len), 1'b0);
        repeat (len - 2) send_byte(8'($urandom), 1'b0);
    endtask

    function automatic int pick_length();
        return ($urandom_range(99) < 90) ? int'($urandom_range(2, 12))
                                         : int'($urandom_range(13, 400));
    endfunction

    task automatic send_file();
        int n;
        int k;
        int pick;
        int ending;
        if ($urandom_range(99) < 15) begin
            // noise and broken files
            n = $urandom_range(1, 48);
            for (k = 0; k < n; k++)
                send_byte(($urandom_range(99) < 30) ? BYTE_FF : 8'($urandom),
                          k == 0 || $urandom_range(99) < 5);
            return;
        end
        send_byte(BYTE_FF, 1'b1);
        if ($urandom_range(99) < 20) repeat ($urandom_range(1, 3)) send_byte(BYTE_FF, 1'b0);
        send_byte(CODE_SOI, 1'b0);
        repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(99) < 10) send_byte(8'($urandom_range(0, 254)), 1'b0);
            send_byte(BYTE_FF, 1'b0);
            if ($urandom_range(99) < 10) send_byte(BYTE_FF, 1'b0);
            send_segment(pick_code(), pick_length());
        end
        ending = $urandom_range(99);
        if (ending < 40) begin
            send_byte(BYTE_FF, 1'b0);
            send_byte(CODE_SOS, 1'b0);
            if (cfg_scan) begin
                n = $urandom_range(0, 24);
                for (k = 0; k < n; k++) begin
                    pick = $urandom_range(99);
                    if (pick < 8) begin
                        send_byte(BYTE_FF, 1'b0);
                        send_byte(BYTE_ZERO, 1'b0);
                    end else if (pick < 12) begin
                        send_byte(BYTE_FF, 1'b0);
                        send_byte(CODE_RST0 + 8'($urandom_range(0, 7)), 1'b0);
                    end else if (pick < 14) begin
                        send_byte(BYTE_FF, 1'b0);
                        send_byte(BYTE_FF, 1'b0);
                        send_byte(BYTE_ZERO, 1'b0);
                    end else if (pick < 16) begin
                        send_byte(BYTE_FF, 1'b0);
                        send_segment(pick_code(), pick_length());
                    end else begin
                        send_byte(8'($urandom_range(0, 254)), 1'b0);
                    end
                end
                send_byte(BYTE_FF, 1'b0);
                send_byte(CODE_EOI, 1'b0);
            end
        end else if (ending < 75) begin
            send_byte(BYTE_FF, 1'b0);
            send_byte(CODE_EOI, 1'b0);
        end else if (ending < 85) begin
            send_byte(BYTE_FF, 1'b0);
            send_segment(CODE_APP13, pick_length());
        end else if (ending < 95) begin
            send_byte(BYTE_FF, 1'b0);
            send_segment(pick_code(), $urandom_range(0, 1));
        end
    endtask

    // receiver: random stalls, or a long hold when asked
    initial begin
        forever begin
            @(posedge clk);
            if (hold_asked != hold_seen) begin
                hold_seen = hold_asked;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_events.size() == 0) begin
                report_mismatch("event with none pending", {29'd0, event_kind}, 32'd0);
            end else begin
                head_ev = expected_events.pop_front();
                if (event_kind != head_ev.kind)
                    report_mismatch("kind", {29'd0, event_kind}, {29'd0, head_ev.kind});
                if (marker_code != head_ev.code)
                    report_mismatch("code", {24'd0, marker_code}, {24'd0, head_ev.code});
                if (segment_length != head_ev.len)
                    report_mismatch("length", {16'd0, segment_length}, {16'd0, head_ev.len});
                if (marker_offset != head_ev.off)
                    report_mismatch("offset", marker_offset, head_ev.off);
                if (scan_ended != head_ev.ends)
                    report_mismatch("scan ended", {31'd0, scan_ended}, {31'd0, head_ev.ends});
            end
        end
    end

    initial begin
        for (cycle_count = 0; cycle_count < LIMIT_CYCLES; cycle_count++) @(posedge clk);
        $display("timeout with %0d events outstanding", expected_events.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int i;
        int phase;
        int goal;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_COUNT; i++) begin
            if (dir_steps[i].is_cfg) begin
                drain();
                write_reg(dir_steps[i].idx, {8'h00, dir_steps[i].value});
            end else begin
                send_byte(dir_steps[i].value, dir_steps[i].nf, dir_steps[i].pinned,
                          dir_steps[i].ev);
            end
        end

        for (phase = 0; phase < N_PHASES; phase++) begin
            drain();
            write_reg(CFG_START_WINDOW,
                      (phase == 5) ? 16'($urandom_range(3, 100)) : PHASE_WINDOW[phase]);
            write_reg(CFG_SCAN_THROUGH,
                      (phase == 5) ? 16'($urandom_range(0, 1)) : {15'd0, PHASE_SCAN[phase]});
            case (phase % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 60; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 60; end
                default: begin send_idle = 36; recv_stall = 36; end
            endcase
            if (phase == 0) begin
                // dense segments against a held receiver
                hold_asked++;
                send_byte(BYTE_FF, 1'b1);
                send_byte(CODE_SOI, 1'b0);
                repeat (24) begin
                    send_byte(BYTE_FF, 1'b0);
                    send_segment(pick_code(), 2);
                end
                send_byte(BYTE_FF, 1'b0);
                send_byte(CODE_EOI, 1'b0);
            end
            goal = sent_bytes + PHASE_ITEMS;
            while (sent_bytes < goal) begin
                if ($urandom_range(99) < 5) drain();
                send_file();
            end
        end

        drain();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
